### src/mtm_pkg.sv
package mtm_pkg;

    localparam int unsigned NUM_W   = 34;  // signed numerator of one matrix entry
    localparam int unsigned N2_W    = 33;  // unsigned squared norm of the quaternion
    localparam int unsigned QUOT_W  = 25;  // quotient bits, the result never exceeds 2^24
    localparam int unsigned DEN_W   = N2_W + 1;
    localparam int unsigned DIVN_W  = 59;
    localparam int unsigned FRONT_LAT = 2;
    localparam int unsigned LANE_LAT  = QUOT_W + 3;
    localparam int unsigned TOTAL_LAT = FRONT_LAT + LANE_LAT;

    typedef struct packed {
        logic [15:0]        scale;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
    } result_t;

    typedef struct packed {
        logic [15:0]                 scale;
        logic [N2_W-1:0]             n2;
        logic [8:0][NUM_W-1:0]       num;
    } coef_t;

endpackage

### src/mtm_front.sv
module mtm_front (
    input  logic            clk,
    input  logic            en,
    input  mtm_pkg::item_t  item,
    output mtm_pkg::coef_t  coef
);

    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    logic [15:0]        scale_reg;
    mtm_pkg::coef_t     coef_reg;
    mtm_pkg::coef_t     coef_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg    <= item.quat_w * item.quat_w;
            xx_reg    <= item.quat_x * item.quat_x;
            yy_reg    <= item.quat_y * item.quat_y;
            zz_reg    <= item.quat_z * item.quat_z;
            xy_reg    <= item.quat_x * item.quat_y;
            xz_reg    <= item.quat_x * item.quat_z;
            yz_reg    <= item.quat_y * item.quat_z;
            xw_reg    <= item.quat_x * item.quat_w;
            yw_reg    <= item.quat_y * item.quat_w;
            zw_reg    <= item.quat_z * item.quat_w;
            scale_reg <= item.scale;
            coef_reg  <= coef_next;
        end
    end

    logic signed [35:0] n2_s;
    logic signed [35:0] t [9];

    always_comb
    begin
        n2_s = 36'(ww_reg) + 36'(xx_reg) + 36'(yy_reg) + 36'(zz_reg);
        t[0] = n2_s - 36'(2) * (36'(yy_reg) + 36'(zz_reg));
        t[1] = 36'(2) * (36'(xy_reg) - 36'(zw_reg));
        t[2] = 36'(2) * (36'(xz_reg) + 36'(yw_reg));
        t[3] = 36'(2) * (36'(xy_reg) + 36'(zw_reg));
        t[4] = n2_s - 36'(2) * (36'(xx_reg) + 36'(zz_reg));
        t[5] = 36'(2) * (36'(yz_reg) - 36'(xw_reg));
        t[6] = 36'(2) * (36'(xz_reg) - 36'(yw_reg));
        t[7] = 36'(2) * (36'(yz_reg) + 36'(xw_reg));
        t[8] = n2_s - 36'(2) * (36'(xx_reg) + 36'(yy_reg));
        coef_next.scale = scale_reg;
        if (n2_s == 36'sd0)
        begin
            // A zero quaternion stands for the identity rotation.
            coef_next.n2 = mtm_pkg::N2_W'(1);
            for (int i = 0; i < 9; i++)
            begin
                coef_next.num[i] = (i == 0 || i == 4 || i == 8) ?
                                   mtm_pkg::NUM_W'(1) : '0;
            end
        end
        else
        begin
            coef_next.n2 = n2_s[mtm_pkg::N2_W-1:0];
            for (int i = 0; i < 9; i++)
            begin
                coef_next.num[i] = t[i][mtm_pkg::NUM_W-1:0];
            end
        end
    end

    assign coef = coef_reg;

endmodule

### src/mtm_lane.sv
module mtm_lane (
    input  logic                          clk,
    input  logic                          en,
    input  logic [15:0]                   scale,
    input  logic [mtm_pkg::NUM_W-1:0]     num,
    input  logic [mtm_pkg::N2_W-1:0]      n2,
    output logic signed [31:0]            res
);

    localparam int unsigned QW = mtm_pkg::QUOT_W;

    logic [48:0]                  mag_reg;
    logic                         neg0_reg;
    logic [mtm_pkg::N2_W-1:0]     d0_reg;

    logic [mtm_pkg::DIVN_W-1:0]   rem_reg [QW+1];
    logic [mtm_pkg::DEN_W-1:0]    den_reg [QW+1];
    logic [QW-1:0]                q_reg   [QW+1];
    logic                         neg_reg [QW+1];
    logic signed [31:0]           res_reg;

    logic [mtm_pkg::NUM_W-1:0]    abs_num;
    logic signed [31:0]           res_next;

    assign abs_num = num[mtm_pkg::NUM_W-1] ? (~num + 1'b1) : num;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= abs_num[32:0] * scale;
            neg0_reg    <= num[mtm_pkg::NUM_W-1];
            d0_reg      <= n2;
            // Round to nearest: floor((512*mag + d) / (2*d)).
            rem_reg[0]  <= {1'b0, mag_reg, 9'b0} + mtm_pkg::DIVN_W'(d0_reg);
            den_reg[0]  <= {d0_reg, 1'b0};
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg0_reg;
            res_reg     <= res_next;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        localparam int unsigned B = QW - k;
        logic [mtm_pkg::DIVN_W-1:0] sub;
        logic [mtm_pkg::DIVN_W:0]   trial;

        assign sub   = mtm_pkg::DIVN_W'(den_reg[k-1]) << B;
        assign trial = {1'b0, rem_reg[k-1]} - {1'b0, sub};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                if (!trial[mtm_pkg::DIVN_W])
                begin
                    rem_reg[k]  <= trial[mtm_pkg::DIVN_W-1:0];
                    q_reg[k]    <= q_reg[k-1] | (QW'(1) << B);
                end
                else
                begin
                    rem_reg[k]  <= rem_reg[k-1];
                    q_reg[k]    <= q_reg[k-1];
                end
            end
        end
    end

    logic [32:0] q_ext;

    always_comb
    begin
        q_ext = 33'(q_reg[QW]);
        if (!neg_reg[QW])
        begin
            res_next = (q_ext > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : signed'(q_ext[31:0]);
        end
        else
        begin
            res_next = (q_ext > 33'h080000000) ? 32'sh80000000 :
                       signed'(32'(~q_ext[31:0] + 32'd1));
        end
    end

    assign res = res_reg;

endmodule

### src/model_transform_matrix.sv
// Model transform matrix builder.
// Input channel (item, item_valid, item_stall) carries one object transform:
// scale (unsigned Q8.8), position (Q16.16) and an orientation quaternion
// (Q2.14, any length). Output channel (result, result_valid, result_stall)
// carries the upper three rows of the 4x4 model matrix in Q16.16; the
// bottom row is always 0 0 0 1 and is not sent.
// One item is taken every cycle while item_stall is low: two stages form
// the quaternion products and numerators, then nine lanes each scale one
// numerator with a 33x16 multiplier, add the rounding bias in one stage
// and divide by the squared norm with a 25-stage restoring divider, one
// quotient bit per stage, followed by a sign and saturation stage.
// Reset clears all valid bits; data registers are not reset.
// While result_valid is high and result_stall is high the whole pipeline
// holds and item_stall is raised; bubbles move on while the output is free.
module model_transform_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  mtm_pkg::item_t    item,
    input  logic              item_valid,
    output logic              item_stall,
    output mtm_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int unsigned LAT = mtm_pkg::TOTAL_LAT;

    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;
    logic signed [31:0] px_reg [LAT];
    logic signed [31:0] py_reg [LAT];
    logic signed [31:0] pz_reg [LAT];
    logic               en;
    mtm_pkg::coef_t     coef;
    logic signed [31:0] m [9];

    assign en         = !(vld_reg[LAT-1] && result_stall);
    assign item_stall = !en;
    assign vld_next   = {vld_reg[LAT-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= item.pos_x;
            py_reg[0] <= item.pos_y;
            pz_reg[0] <= item.pos_z;
            for (int i = 1; i < LAT; i++)
            begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end
        end
    end

    mtm_front u_front (
        .clk  (clk),
        .en   (en),
        .item (item),
        .coef (coef)
    );

    for (genvar j = 0; j < 9; j++)
    begin : g_lane
        mtm_lane u_lane (
            .clk   (clk),
            .en    (en),
            .scale (coef.scale),
            .num   (coef.num[j]),
            .n2    (coef.n2),
            .res   (m[j])
        );
    end

    always_comb
    begin
        result.m00 = m[0];
        result.m01 = m[1];
        result.m02 = m[2];
        result.m03 = px_reg[LAT-1];
        result.m10 = m[3];
        result.m11 = m[4];
        result.m12 = m[5];
        result.m13 = py_reg[LAT-1];
        result.m20 = m[6];
        result.m21 = m[7];
        result.m22 = m[8];
        result.m23 = pz_reg[LAT-1];
    end

    assign result_valid = vld_reg[LAT-1];

endmodule
